/* rtl/ttsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transposition table package
// Shared widths, codes, default register values and interface types of the
// direct-mapped transposition table.
// ----------------------------------------------------------------------------
package ttsp_pkg;

    localparam int HASH_BITS        = 64;
    localparam int TAG_BITS         = 32;
    localparam int TAG_SHIFT        = 32;
    localparam int SCORE_BITS       = 16;
    localparam int DEPTH_BITS       = 8;
    localparam int MOVE_IN_BITS     = 16;
    localparam int ENTRY_FIXED_BITS = TAG_BITS + 2 * SCORE_BITS + 2 * DEPTH_BITS;

    localparam int INDEX_BITS_DEFAULT = 10;
    localparam int MOVE_BITS_DEFAULT  = 16;

    localparam int S_TDATA_BITS  = HASH_BITS + DEPTH_BITS + SCORE_BITS + MOVE_IN_BITS;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 2 * SCORE_BITS + 2 * DEPTH_BITS + MOVE_IN_BITS;
    localparam int M_TUSER_BITS  = 1;
    localparam int CFG_ADDR_BITS = 8;
    localparam int CFG_DATA_BITS = SCORE_BITS;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_DEFAULT_UPPER = 8'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DEFAULT_LOWER = 8'd1;

    localparam logic signed [SCORE_BITS-1:0] DEFAULT_UPPER_RESET = 16'sh7FFF;
    localparam logic signed [SCORE_BITS-1:0] DEFAULT_LOWER_RESET = 16'sh8001;

    typedef struct packed {
        logic                         op;
        logic [TAG_BITS-1:0]          tag;
        logic [DEPTH_BITS-1:0]        depth;
        logic                         is_lower;
        logic signed [SCORE_BITS-1:0] score;
        logic [MOVE_IN_BITS-1:0]      move;
    } req_t;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] default_upper;
        logic signed [SCORE_BITS-1:0] default_lower;
    } cfg_t;

    typedef struct packed {
        logic                         hit;
        logic signed [SCORE_BITS-1:0] low_score;
        logic signed [SCORE_BITS-1:0] high_score;
        logic [DEPTH_BITS-1:0]        low_depth;
        logic [DEPTH_BITS-1:0]        high_depth;
        logic [MOVE_IN_BITS-1:0]      move_out;
    } res_t;

endpackage
`default_nettype wire

/* rtl/ttsp_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the default bounds written into a newly replaced table entry.
// ----------------------------------------------------------------------------
module ttsp_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ttsp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [ttsp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output ttsp_pkg::cfg_t                    cfg_out
);
    import ttsp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_upper <= DEFAULT_UPPER_RESET;
            cfg_reg.default_lower <= DEFAULT_LOWER_RESET;
        end else if (cfg_valid) begin
            if (cfg_addr == CFG_DEFAULT_UPPER) begin
                cfg_reg.default_upper <= cfg_wdata;
            end else if (cfg_addr == CFG_DEFAULT_LOWER) begin
                cfg_reg.default_lower <= cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ttsp_table_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry table memory
// Single-port-write, registered-read table with a clearing pass after reset.
// ----------------------------------------------------------------------------
module ttsp_table_mem #(
    parameter int INDEX_BITS = ttsp_pkg::INDEX_BITS_DEFAULT,
    parameter int ENTRY_BITS = ttsp_pkg::ENTRY_FIXED_BITS + ttsp_pkg::MOVE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [INDEX_BITS-1:0] rd_addr,
    output logic [ENTRY_BITS-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  logic [ENTRY_BITS-1:0] wr_data,
    output logic                  clearing
);
    localparam int DEPTH = 2 ** INDEX_BITS;

    logic [ENTRY_BITS-1:0] table_reg [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [INDEX_BITS-1:0] clr_addr_next;
    logic                  clearing_reg;
    logic                  clearing_next;
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    logic [ENTRY_BITS-1:0] wdata;

    assign clearing = clearing_reg;
    assign rd_data  = rd_data_reg;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + INDEX_BITS'(1);
            if (&clr_addr_reg) begin
                clearing_next = 1'b0;
            end
        end
        we    = clearing_reg | wr_en;
        waddr = clearing_reg ? clr_addr_reg : wr_addr;
        wdata = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            table_reg[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= table_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/ttsp_entry_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry update
// Compares tags and forms the written-back entry and the probe result.
// ----------------------------------------------------------------------------
module ttsp_entry_update #(
    parameter int MOVE_BITS  = ttsp_pkg::MOVE_BITS_DEFAULT,
    parameter int ENTRY_BITS = ttsp_pkg::ENTRY_FIXED_BITS + ttsp_pkg::MOVE_BITS_DEFAULT
) (
    input  ttsp_pkg::req_t        req,
    input  ttsp_pkg::cfg_t        cfg,
    input  logic [ENTRY_BITS-1:0] entry_in,
    output logic [ENTRY_BITS-1:0] entry_out,
    output ttsp_pkg::res_t        res
);
    import ttsp_pkg::*;

    localparam int MOVE_LO     = TAG_BITS;
    localparam int LO_SCORE_LO = MOVE_LO + MOVE_BITS;
    localparam int HI_SCORE_LO = LO_SCORE_LO + SCORE_BITS;
    localparam int LO_DEPTH_LO = HI_SCORE_LO + SCORE_BITS;
    localparam int HI_DEPTH_LO = LO_DEPTH_LO + DEPTH_BITS;

    logic [TAG_BITS-1:0]          tag_e;
    logic [MOVE_BITS-1:0]         move_e;
    logic signed [SCORE_BITS-1:0] lo_score_e;
    logic signed [SCORE_BITS-1:0] hi_score_e;
    logic [DEPTH_BITS-1:0]        lo_depth_e;
    logic [DEPTH_BITS-1:0]        hi_depth_e;
    logic signed [SCORE_BITS-1:0] lo_score_n;
    logic signed [SCORE_BITS-1:0] hi_score_n;
    logic [DEPTH_BITS-1:0]        lo_depth_n;
    logic [DEPTH_BITS-1:0]        hi_depth_n;
    logic                         hit;

    always_comb begin
        tag_e      = entry_in[TAG_BITS-1:0];
        move_e     = entry_in[MOVE_LO +: MOVE_BITS];
        lo_score_e = entry_in[LO_SCORE_LO +: SCORE_BITS];
        hi_score_e = entry_in[HI_SCORE_LO +: SCORE_BITS];
        lo_depth_e = entry_in[LO_DEPTH_LO +: DEPTH_BITS];
        hi_depth_e = entry_in[HI_DEPTH_LO +: DEPTH_BITS];
        hit        = (tag_e == req.tag);

        lo_score_n = lo_score_e;
        hi_score_n = hi_score_e;
        lo_depth_n = lo_depth_e;
        hi_depth_n = hi_depth_e;
        if (hit) begin
            if (req.is_lower) begin
                lo_score_n = req.score;
                lo_depth_n = req.depth;
            end else begin
                hi_score_n = req.score;
                hi_depth_n = req.depth;
            end
        end else begin
            lo_score_n = req.is_lower ? req.score : cfg.default_lower;
            hi_score_n = req.is_lower ? cfg.default_upper : req.score;
            lo_depth_n = req.depth;
            hi_depth_n = req.depth;
        end

        entry_out = {hi_depth_n, lo_depth_n, hi_score_n, lo_score_n,
                     MOVE_BITS'(req.move), req.tag};

        res.hit = hit;
        if (hit) begin
            res.low_score  = lo_score_e;
            res.high_score = hi_score_e;
            res.low_depth  = lo_depth_e;
            res.high_depth = hi_depth_e;
            res.move_out   = MOVE_IN_BITS'(move_e);
        end else begin
            res.low_score  = '0;
            res.high_score = '0;
            res.low_depth  = '0;
            res.high_depth = '0;
            res.move_out   = '0;
        end
    end

endmodule
`default_nettype wire

/* rtl/transposition_table_store_probe_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A probe's word and its table entry are registered on acceptance; the result
// then goes to the output register once that register is free. A new word
// is taken only when the last is done: a store's entry is written back, a
// probe's result loaded. Reset: a clearing pass writes every entry to zero
// with s_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Transposition table store and probe
// Direct-mapped table of search results with read-modify-write of one entry.
// ----------------------------------------------------------------------------
module transposition_table_store_probe_top #(
    parameter int INDEX_BITS = ttsp_pkg::INDEX_BITS_DEFAULT,
    parameter int MOVE_BITS  = ttsp_pkg::MOVE_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // hash_key[63:0], search_depth[71:64], score_in[87:72], move_in[103:88]
    input  logic [ttsp_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // op[0], is_lower_bound[1]
    input  logic [ttsp_pkg::S_TUSER_BITS-1:0]  s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // low_score[15:0], high_score[31:16], low_depth[39:32], high_depth[47:40],
    // move_out[63:48]
    output logic [ttsp_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // hit[0]
    output logic [ttsp_pkg::M_TUSER_BITS-1:0]  m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttsp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [ttsp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import ttsp_pkg::*;

    localparam int ENTRY_BITS = ENTRY_FIXED_BITS + MOVE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    req_t                  req_reg;
    req_t                  req_in;
    logic [INDEX_BITS-1:0] idx_reg;
    res_t                  out_reg;
    res_t                  res;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic                  accept;
    logic                  load_out;
    logic                  wr_en;
    logic                  clearing;
    cfg_t                  cfg;
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [ENTRY_BITS-1:0] wr_entry;

    ttsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg_out   (cfg)
    );

    ttsp_table_mem #(
        .INDEX_BITS (INDEX_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (s_tdata[INDEX_BITS-1:0]),
        .rd_data  (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (idx_reg),
        .wr_data  (wr_entry),
        .clearing (clearing)
    );

    ttsp_entry_update #(
        .MOVE_BITS  (MOVE_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_upd (
        .req       (req_reg),
        .cfg       (cfg),
        .entry_in  (rd_entry),
        .entry_out (wr_entry),
        .res       (res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        req_in.op       = s_tuser[0];
        req_in.is_lower = s_tuser[1];
        req_in.tag      = s_tdata[TAG_SHIFT +: TAG_BITS];
        req_in.depth    = s_tdata[HASH_BITS +: DEPTH_BITS];
        req_in.score    = s_tdata[HASH_BITS + DEPTH_BITS +: SCORE_BITS];
        req_in.move     = s_tdata[HASH_BITS + DEPTH_BITS + SCORE_BITS +: MOVE_IN_BITS];
    end

    always_comb begin
        state_next    = state_reg;
        wr_en         = 1'b0;
        load_out      = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        unique case (state_reg)
            ST_CLEAR: begin
                if (!clearing) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (req_reg.op == OP_STORE) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else if (!m_tvalid_reg || m_tready) begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_in;
            idx_reg <= s_tdata[INDEX_BITS-1:0];
        end
        if (load_out) begin
            out_reg <= res;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = out_reg.hit;
    assign m_tdata    = {out_reg.move_out, out_reg.high_depth, out_reg.low_depth,
                         out_reg.high_score, out_reg.low_score};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table store and probe testbench
// Drives store and probe words into the direct-mapped table under random
// sender bursts and receiver stalls, with a long receiver hold-off so that
// the block fills up. A scoreboard class keeps its own copy of the table and
// of the default bounds, predicts each probe result and compares every
// returned word field by field. The run steps through several settings of
// the default bounds, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import ttsp_pkg::*;

    localparam int TBL_INDEX_BITS   = INDEX_BITS_DEFAULT;
    localparam int TABLE_SIZE       = 1 << TBL_INDEX_BITS;
    localparam int POOL_SIZE        = 12;
    localparam int RANDOM_PER_PHASE = 106;
    localparam int NUM_PHASES       = 5;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_PRINTED      = 100;

    localparam logic BOUND_LOWER = 1'b1;
    localparam logic BOUND_UPPER = 1'b0;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED_FIRST = 8'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED_LAST  = 8'hFF;

    typedef struct packed {
        logic                         op;
        logic [HASH_BITS-1:0]         hash_key;
        logic [DEPTH_BITS-1:0]        depth;
        logic                         is_lower;
        logic signed [SCORE_BITS-1:0] score;
        logic [MOVE_IN_BITS-1:0]      move;
    } tt_word_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]          tag;
        logic [MOVE_IN_BITS-1:0]      move;
        logic signed [SCORE_BITS-1:0] lo_score;
        logic signed [SCORE_BITS-1:0] hi_score;
        logic [DEPTH_BITS-1:0]        lo_depth;
        logic [DEPTH_BITS-1:0]        hi_depth;
    } tt_slot_t;

    class tt_scoreboard;
        tt_slot_t                     slots[TABLE_SIZE];
        logic signed [SCORE_BITS-1:0] dflt_upper;
        logic signed [SCORE_BITS-1:0] dflt_lower;
        res_t                         probe_results_q[$];
        int                           mismatches;

        function new();
            foreach (slots[i]) slots[i] = '0;
            dflt_upper = DEFAULT_UPPER_RESET;
            dflt_lower = DEFAULT_LOWER_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_DEFAULT_UPPER: dflt_upper = val;
                CFG_DEFAULT_LOWER: dflt_lower = val;
                default: ;
            endcase
        endfunction

        function void note_word(tt_word_t w);
            logic [TBL_INDEX_BITS-1:0] idx;
            logic [TAG_BITS-1:0]       tag;
            res_t                      want;
            idx  = w.hash_key[TBL_INDEX_BITS-1:0];
            tag  = w.hash_key[TAG_SHIFT +: TAG_BITS];
            want = '0;
            if (w.op == OP_STORE) begin
                if (slots[idx].tag == tag) begin
                    slots[idx].move = w.move;
                    if (w.is_lower == BOUND_LOWER) begin
                        slots[idx].lo_score = w.score;
                        slots[idx].lo_depth = w.depth;
                    end else begin
                        slots[idx].hi_score = w.score;
                        slots[idx].hi_depth = w.depth;
                    end
                end else begin
                    // A new position takes the whole entry; the bound not
                    // being stored comes from the configured default.
                    slots[idx].tag  = tag;
                    slots[idx].move = w.move;
                    if (w.is_lower == BOUND_LOWER) begin
                        slots[idx].lo_score = w.score;
                        slots[idx].hi_score = dflt_upper;
                    end else begin
                        slots[idx].lo_score = dflt_lower;
                        slots[idx].hi_score = w.score;
                    end
                    slots[idx].lo_depth = w.depth;
                    slots[idx].hi_depth = w.depth;
                end
            end else begin
                if (slots[idx].tag == tag) begin
                    want.hit        = 1'b1;
                    want.low_score  = slots[idx].lo_score;
                    want.high_score = slots[idx].hi_score;
                    want.low_depth  = slots[idx].lo_depth;
                    want.high_depth = slots[idx].hi_depth;
                    want.move_out   = slots[idx].move;
                end
                probe_results_q.push_back(want);
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_result(res_t got);
            res_t want;
            if (probe_results_q.size() == 0) begin
                report("result word with no probe outstanding");
            end else begin
                want = probe_results_q.pop_front();
                check_field("hit", int'(got.hit), int'(want.hit));
                check_field("low_score", int'(got.low_score), int'(want.low_score));
                check_field("high_score", int'(got.high_score), int'(want.high_score));
                check_field("low_depth", int'(got.low_depth), int'(want.low_depth));
                check_field("high_depth", int'(got.high_depth), int'(want.high_depth));
                check_field("move_out", int'(got.move_out), int'(want.move_out));
            end
        endtask

        function int pending();
            return probe_results_q.size();
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic [S_TDATA_BITS-1:0]  s_tdata   = '0;
    logic [S_TUSER_BITS-1:0]  s_tuser   = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic [M_TUSER_BITS-1:0]  m_tuser;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    tt_scoreboard       sb = new();
    logic [HASH_BITS-1:0] key_pool[POOL_SIZE];
    int                 burst_left = 0;
    int                 cycle_count = 0;
    logic               hold_req = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_left = 0;
    int                 rx_mode = 0;
    int                 rx_left = 0;

    transposition_table_store_probe_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall patterns, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(5, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        res_t     seen;
        tt_word_t taken;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_addr, cfg_wdata);
            if (m_tvalid && m_tready) begin
                seen.hit        = m_tuser[0];
                seen.low_score  = m_tdata[15:0];
                seen.high_score = m_tdata[31:16];
                seen.low_depth  = m_tdata[39:32];
                seen.high_depth = m_tdata[47:40];
                seen.move_out   = m_tdata[63:48];
                sb.check_result(seen);
            end
            if (s_tvalid && s_tready) begin
                taken.op       = s_tuser[0];
                taken.is_lower = s_tuser[1];
                taken.hash_key = s_tdata[63:0];
                taken.depth    = s_tdata[71:64];
                taken.score    = s_tdata[87:72];
                taken.move     = s_tdata[103:88];
                sb.note_word(taken);
            end
        end
    end

    function automatic tt_word_t word_of(logic op, logic [HASH_BITS-1:0] key,
                                         logic [DEPTH_BITS-1:0] depth, logic is_lower,
                                         logic [SCORE_BITS-1:0] score,
                                         logic [MOVE_IN_BITS-1:0] move);
        tt_word_t w;
        w.op       = op;
        w.hash_key = key;
        w.depth    = depth;
        w.is_lower = is_lower;
        w.score    = score;
        w.move     = move;
        return w;
    endfunction

    // Keys share a handful of table slots so that hits, updates and
    // replacements all occur often.
    task automatic build_key_pool();
        logic [TAG_BITS-1:0] tags[4];
        logic [HASH_BITS-1:0] k;
        tags[0] = '0;
        tags[1] = '1;
        tags[2] = $urandom;
        tags[3] = $urandom;
        foreach (key_pool[i]) begin
            k = {$urandom, $urandom};
            k[TBL_INDEX_BITS-1:0] = ($urandom_range(0, 4) == 0) ?
                                    TBL_INDEX_BITS'(TABLE_SIZE - 1) :
                                    TBL_INDEX_BITS'($urandom_range(0, 7));
            k[TAG_SHIFT +: TAG_BITS] = tags[$urandom_range(0, 3)];
            key_pool[i] = k;
        end
    endtask

    function automatic tt_word_t random_word();
        tt_word_t w;
        int       pick;
        pick       = $urandom_range(0, 99);
        w.hash_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        w.hash_key[TAG_SHIFT-1:TBL_INDEX_BITS] = (TAG_SHIFT - TBL_INDEX_BITS)'($urandom);
        if (pick >= 90)
            w.hash_key = {$urandom, $urandom};
        else if (pick >= 75)
            w.hash_key[TAG_SHIFT +: TAG_BITS] = $urandom;
        w.op       = $urandom_range(0, 1) ? OP_PROBE : OP_STORE;
        w.is_lower = 1'($urandom_range(0, 1));
        w.move     = MOVE_IN_BITS'($urandom);
        case ($urandom_range(0, 7))
            0: w.depth = '0;
            1: w.depth = '1;
            default: w.depth = DEPTH_BITS'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: w.score = 16'sh8000;
            1: w.score = 16'sh7FFF;
            default: w.score = SCORE_BITS'($urandom);
        endcase
        return w;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_word(tt_word_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= {w.move, w.score, w.depth, w.hash_key};
        s_tuser  <= {w.is_lower, w.op};
        do @(posedge aclk); while (!s_tready);
        pace();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] upper, logic [CFG_DATA_BITS-1:0] lower,
                             bit with_unused);
        write_reg(CFG_DEFAULT_UPPER, upper);
        write_reg(CFG_DEFAULT_LOWER, lower);
        if (with_unused) begin
            write_reg(CFG_UNUSED_FIRST, CFG_DATA_BITS'($urandom));
            write_reg(CFG_UNUSED_LAST, CFG_DATA_BITS'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset defaults.
        send_word(word_of(OP_PROBE, 64'h0, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_PROBE, '1, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, '1, 8'd255, BOUND_LOWER, 16'h7FFF, 16'hFFFF));
        send_word(word_of(OP_PROBE, '1, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, '1, 8'd0, BOUND_UPPER, 16'h8000, 16'h0000));
        send_word(word_of(OP_PROBE, '1, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'h1234_5678_0000_0005, 8'd9, BOUND_UPPER,
                          16'hFFFF, 16'h1234));
        send_word(word_of(OP_PROBE, 64'h1234_5678_0000_0005, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_PROBE, 64'hEDCB_A987_0000_0005, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'hEDCB_A987_0000_0005, 8'd200, BOUND_LOWER,
                          16'h0005, 16'hABCD));
        send_word(word_of(OP_PROBE, 64'h1234_5678_0000_0005, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_PROBE, 64'hEDCB_A987_0000_0005, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'h7, 8'd3, BOUND_LOWER, 16'd100, 16'd77));
        send_word(word_of(OP_PROBE, 64'h0000_0000_FFFF_FC07, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'hAAAA_AAAA_5555_5555, 8'hAA, BOUND_UPPER,
                          16'h5555, 16'hAAAA));
        send_word(word_of(OP_PROBE, 64'hAAAA_AAAA_5555_5555, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'h5555_5555_AAAA_AAAA, 8'h55, BOUND_LOWER,
                          16'hAAAA, 16'h5555));
        send_word(word_of(OP_PROBE, 64'h5555_5555_AAAA_AAAA, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        send_word(word_of(OP_STORE, 64'h5555_5555_AAAA_AAAA, 8'd1, BOUND_UPPER,
                          16'h0000, 16'h0001));
        send_word(word_of(OP_PROBE, 64'h5555_5555_AAAA_AAAA, 8'd0, BOUND_LOWER, 16'h0, 16'h0));
        send_word(word_of(OP_PROBE, 64'h0000_0001_0000_0000, 8'd0, BOUND_UPPER, 16'h0, 16'h0));
        drain();

        for (phase = 1; phase <= NUM_PHASES; phase++) begin
            case (phase)
                1: configure(16'h7FFF, 16'h8000, 1'b0);
                2: configure(16'h8000, 16'h7FFF, 1'b1);
                3: configure(16'h0000, 16'h0000, 1'b0);
                4: configure(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), 1'b0);
                default: configure(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), 1'b1);
            endcase
            // The long hold-off falls in the second phase, while words keep coming.
            if (phase == 2)
                hold_req <= 1'b1;
            build_key_pool();
            repeat (RANDOM_PER_PHASE) send_word(random_word());
            drain();
        end

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* transposition_table_store_probe_top.f */
rtl/ttsp_pkg.sv
rtl/ttsp_cfg_regs.sv
rtl/ttsp_table_mem.sv
rtl/ttsp_entry_update.sv
rtl/transposition_table_store_probe_top.sv
tb/tb_top.sv
